@@ src/brb_pkg.sv @@
package brb_pkg;

  // Ring geometry; CAPACITY must be a power of two so the counters wrap at 2*CAPACITY
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;

  // Item field widths
  localparam int LEN_W  = 11;
  localparam int LIM_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 3;

  // Largest run a pop request may produce
  localparam int MAX_POP = 64;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Opcode of an incoming item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Command class decided by the front
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_POP_ZERO
  } cmd_kind_t;

  // Result codes
  typedef enum logic [CODE_W-1:0] {
    RES_PUSH_OK   = 3'd0,
    RES_PUSH_REJ  = 3'd1,
    RES_POP_BYTE  = 3'd2,
    RES_POP_EMPTY = 3'd3,
    RES_POP_ZERO  = 3'd4
  } res_code_t;

  // One classified command
  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [LIM_W-1:0]  lim;
  } cmd_t;

endpackage

@@ src/brb_ram.sv @@
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/brb_front.sv @@
module brb_front
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              msg_first,
  input  logic              msg_last,
  input  logic [LEN_W-1:0]  msg_len,
  input  logic [LIM_W-1:0]  pop_max,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_take
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              accept;
  cmd_t              cls;

  assign busy   = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  // Classify: zero-limit pops get their own class, large limits saturate
  always_comb begin
    cls.data  = data_byte;
    cls.first = msg_first;
    cls.last  = msg_last;
    cls.len   = msg_len;
    cls.lim   = pop_max;
    if (opcode == OP_PUSH) begin
      cls.kind = CMD_PUSH;
    end else if (pop_max == '0) begin
      cls.kind = CMD_POP_ZERO;
    end else begin
      cls.kind = CMD_POP;
      if (pop_max > LIM_W'(MAX_POP)) begin
        cls.lim = LIM_W'(MAX_POP);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !cmd_take) begin
        fill <= fill + 1'b1;
      end else if (!accept && cmd_take) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

endmodule

@@ src/brb_back.sv @@
module brb_back
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  output logic              strobe,
  output logic [CODE_W-1:0] result_code,
  output logic [BYTE_W-1:0] data_byte_out,
  output logic [LIM_W-1:0]  pop_count,
  output logic              last
);

  // Ring state
  logic [CNT_W-1:0] read_count, read_count_next;
  logic [CNT_W-1:0] write_count, write_count_next;
  logic [CNT_W-1:0] pending_write_pos, pending_write_pos_next;
  logic             message_accepted, message_accepted_next;
  logic [LEN_W-1:0] msg_room, msg_room_next;

  // Pop run state
  logic [LIM_W-1:0] run_left, run_left_next;
  logic [LIM_W-1:0] run_n, run_n_next;

  // Result stage, aligned with the registered RAM read
  logic             res_valid, res_valid_next;
  res_code_t        res_code, res_code_next;
  logic [LIM_W-1:0] res_count, res_count_next;
  logic             res_last, res_last_next;
  logic             res_byte, res_byte_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [CNT_W-1:0]  stored;
  logic [CNT_W-1:0]  free_space;
  logic              issue;
  logic [LIM_W-1:0]  issue_count;
  logic              reject;

  brb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.data),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stored     = write_count - read_count;
  assign free_space = CNT_W'(CAPACITY) - stored;
  assign reject     = (cmd.len == '0) || (32'(cmd.len) > CAPACITY)
                      || (CNT_W'(cmd.len) > free_space);
  assign ram_raddr  = read_count[ADDR_W-1:0];

  // Command execution: continue a pop run, or take the next command
  always_comb begin
    read_count_next        = read_count;
    write_count_next       = write_count;
    pending_write_pos_next = pending_write_pos;
    message_accepted_next  = message_accepted;
    msg_room_next          = msg_room;
    run_left_next          = run_left;
    run_n_next             = run_n;
    res_valid_next         = 1'b0;
    res_code_next          = RES_PUSH_OK;
    res_count_next         = '0;
    res_last_next          = 1'b1;
    res_byte_next          = 1'b0;
    cmd_take               = 1'b0;
    ram_we                 = 1'b0;
    ram_waddr              = pending_write_pos[ADDR_W-1:0];
    issue                  = 1'b0;
    issue_count            = run_n;

    if (run_left != '0) begin
      issue         = 1'b1;
      run_left_next = run_left - 1'b1;
    end else if (cmd_valid) begin
      cmd_take = 1'b1;
      unique case (cmd.kind)
        CMD_PUSH: begin
          // Length check at the first byte opens or refuses the message
          if (cmd.first) begin
            if (reject) begin
              message_accepted_next = 1'b0;
              msg_room_next         = '0;
            end else begin
              message_accepted_next  = 1'b1;
              msg_room_next          = cmd.len;
              pending_write_pos_next = write_count;
            end
          end
          if (message_accepted_next && msg_room_next != '0) begin
            ram_we                 = 1'b1;
            ram_waddr              = pending_write_pos_next[ADDR_W-1:0];
            pending_write_pos_next = pending_write_pos_next + 1'b1;
            msg_room_next          = msg_room_next - 1'b1;
          end
          // Last byte commits or reports the rejection
          if (cmd.last) begin
            res_valid_next = 1'b1;
            if (message_accepted_next) begin
              res_code_next    = RES_PUSH_OK;
              write_count_next = pending_write_pos_next;
            end else begin
              res_code_next = RES_PUSH_REJ;
            end
            message_accepted_next = 1'b0;
            msg_room_next         = '0;
          end
        end
        CMD_POP_ZERO: begin
          res_valid_next = 1'b1;
          res_code_next  = RES_POP_ZERO;
        end
        CMD_POP: begin
          if (stored == '0) begin
            res_valid_next = 1'b1;
            res_code_next  = RES_POP_EMPTY;
          end else begin
            issue_count   = (stored < CNT_W'(cmd.lim)) ? LIM_W'(stored) : cmd.lim;
            issue         = 1'b1;
            run_n_next    = issue_count;
            run_left_next = issue_count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // One pop byte read per cycle
    if (issue) begin
      res_valid_next  = 1'b1;
      res_code_next   = RES_POP_BYTE;
      res_count_next  = issue_count;
      res_last_next   = (run_left_next == '0);
      res_byte_next   = 1'b1;
      read_count_next = read_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count        <= '0;
      write_count       <= '0;
      pending_write_pos <= '0;
      message_accepted  <= 1'b0;
      msg_room          <= '0;
      run_left          <= '0;
      run_n             <= '0;
      res_valid         <= 1'b0;
    end else begin
      read_count        <= read_count_next;
      write_count       <= write_count_next;
      pending_write_pos <= pending_write_pos_next;
      message_accepted  <= message_accepted_next;
      msg_room          <= msg_room_next;
      run_left          <= run_left_next;
      run_n             <= run_n_next;
      res_valid         <= res_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_code  <= res_code_next;
    res_count <= res_count_next;
    res_last  <= res_last_next;
    res_byte  <= res_byte_next;
  end

  assign strobe        = res_valid;
  assign result_code   = res_code;
  assign data_byte_out = res_byte ? ram_rdata : '0;
  assign pop_count     = res_count;
  assign last          = res_last;

endmodule

@@ src/byte_ring_buffer_fifo_unit.sv @@
// Byte ring buffer of 1024 bytes with all-or-nothing message push and
// bounded pop. Items are taken when start is high and busy is low; they go
// into a four-entry command queue, so busy rises only when that queue is
// full. The back end executes one push byte per cycle while no pop run is
// in progress; a pop request of n bytes (n = min(stored, limit), at most
// 64) occupies it until its last byte is issued, one RAM read per byte.
// Each result appears for one cycle with strobe high and cannot be
// stalled; it follows in the cycle right after the back end takes its
// command, except for the further bytes of a pop run, which follow without
// gaps. Items pass the command queue and then the result register.
// No clearing pass after reset: only committed bytes are ever read.
module byte_ring_buffer_fifo_unit
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              msg_first,
  input  logic              msg_last,
  input  logic [LEN_W-1:0]  msg_len,
  input  logic [LIM_W-1:0]  pop_max,
  output logic              strobe,
  output logic [CODE_W-1:0] result_code,
  output logic [BYTE_W-1:0] data_byte_out,
  output logic [LIM_W-1:0]  pop_count,
  output logic              last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // Accept and classify
  brb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .data_byte(data_byte),
    .msg_first(msg_first),
    .msg_last (msg_last),
    .msg_len  (msg_len),
    .pop_max  (pop_max),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // Execute against the ring
  brb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .strobe       (strobe),
    .result_code  (result_code),
    .data_byte_out(data_byte_out),
    .pop_count    (pop_count),
    .last         (last)
  );

endmodule
